// ===== design/path_bezier_flattener_macros.svh =====
`ifndef PATH_BEZIER_FLATTENER_MACROS_SVH
`define PATH_BEZIER_FLATTENER_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled in reset.
`define PBF_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("path flattener check failed");

// Next-cycle implication, sampled on clock and disabled in reset.
`define PBF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("path flattener check failed");

`endif

// ===== design/pbf_pkg.sv =====
`timescale 1ns / 1ps
package pbf_pkg;

   localparam int COORD_W = 24;
   localparam int CMD_W = 3;
   localparam int TOL_W = 24;
   localparam int MAX_DEPTH_DEFAULT = 6;
   localparam logic [TOL_W-1:0] TOL_RESET = 24'd16384;

   // floor(u / 3) = (u * RECIP3) >> RECIP3_SHIFT for u below 2^27.
   localparam logic [27:0] RECIP3 = 28'd89478486;
   localparam int RECIP3_SHIFT = 28;

   localparam logic [3:0] QUAD_LAST = 4'd4;
   localparam logic [3:0] TEST_LAST = 4'd12;

   typedef enum logic [CMD_W-1:0] {
      CMD_MOVE  = 3'd0,
      CMD_LINE  = 3'd1,
      CMD_QUAD  = 3'd2,
      CMD_CUBIC = 3'd3,
      CMD_CLOSE = 3'd4
   } pbf_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUAD,
      ST_DECIDE,
      ST_TEST,
      ST_SPLIT,
      ST_EMIT,
      ST_POP
   } pbf_state_type;

   function automatic logic signed [COORD_W-1:0] half_sum(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] s;
      s = COORD_W'(0) + ((COORD_W+1)'(a) + (COORD_W+1)'(b));
      return s[COORD_W:1];
   endfunction

endpackage

// ===== design/pbf_if.sv =====
`timescale 1ns / 1ps
interface pbf_req_if import pbf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [COORD_W-1:0] end_x;
   logic signed [COORD_W-1:0] end_y;
   logic signed [COORD_W-1:0] ctrl1_x;
   logic signed [COORD_W-1:0] ctrl1_y;
   logic signed [COORD_W-1:0] ctrl2_x;
   logic signed [COORD_W-1:0] ctrl2_y;

   modport source (output valid, command, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                   input ready);
   modport sink (input valid, command, end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                 output ready);
endinterface

interface pbf_rsp_if import pbf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] out_x;
   logic signed [COORD_W-1:0] out_y;
   logic                      starts_contour;
   logic                      last_of_run;

   modport source (output valid, out_x, out_y, starts_contour, last_of_run, input ready);
   modport sink (input valid, out_x, out_y, starts_contour, last_of_run, output ready);
endinterface

interface pbf_csr_if import pbf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [TOL_W-1:0] flatness_tolerance;

   modport source (output valid, flatness_tolerance, input ready);
   modport sink (input valid, flatness_tolerance, output ready);
endinterface

// ===== design/path_bezier_flattener.sv =====
`timescale 1ns / 1ps
// Channel  Role  Carries
// req_ch   sink  path request: command, end point, two control points
// rsp_ch   src   polyline point with contour start and last-of-run flags
// csr_ch   sink  flatness tolerance write, taken in any cycle
//
// Move, line and close pass the emit step; unknown or premature
// requests return straight to idle. Each flatness test of a curve
// runs on the shared 28x28 multiplier, plus a step per split, emit
// and stack pop; a quadratic's raise also uses that multiplier.
// Reset is synchronous, clears the path state and loads TOL_RESET.
// A stalled result holds the engine in its emit step.
`include "path_bezier_flattener_macros.svh"

module path_bezier_flattener import pbf_pkg::*; #(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   pbf_req_if.sink      req_ch,
   pbf_rsp_if.source    rsp_ch,
   pbf_csr_if.sink      csr_ch
);

   localparam int SW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int SEG_W = 8 * COORD_W;

   pbf_state_type state_ff, state_in;
   logic [3:0] step_ff;
   logic [SW-1:0] sp_ff, level_ff;
   logic signed [COORD_W-1:0] px_ff [4];
   logic signed [COORD_W-1:0] py_ff [4];
   logic signed [COORD_W-1:0] cur_x_ff, cur_y_ff, cs_x_ff, cs_y_ff;
   logic has_ff, starts_ff, qneg_ff;
   logic [TOL_W-1:0] tol_ff;

   logic rsp_valid_ff, rsp_starts_ff, rsp_last_ff;
   logic signed [COORD_W-1:0] rsp_x_ff, rsp_y_ff;

   logic signed [55:0] mul_ff;
   logic signed [50:0] t_ff;
   logic [49:0] d_ff, dot_ff;
   logic [50:0] s_ff;
   logic [101:0] lhs_ff;
   logic [75:0] rhs_ff;

   logic [SEG_W-1:0] seg_mem [MAX_DEPTH];
   logic [SW-1:0] lvl_mem [MAX_DEPTH];
   logic [SEG_W-1:0] rd_seg_ff;
   logic [SW-1:0] rd_lvl_ff;

   logic accept, out_free, emit_fire, pop_rd, flat, at_limit;
   logic signed [27:0] mul_a, mul_b;
   logic signed [24:0] dx, dy, e1x, e1y, e2x, e2y, qd;
   logic signed [25:0] qt, tt;
   logic [25:0] qmag, qu;
   logic [24:0] qq;
   logic signed [COORD_W-1:0] qbase, qnew;
   logic signed [50:0] tdiff;
   logic [49:0] tabs;
   logic [51:0] prod;
   logic signed [COORD_W-1:0] ax, bx, cx, abx, bcx, mx, ay, by, cy, aby, bcy, my;
   logic [AW-1:0] rd_addr;
   pbf_cmd_type cmd;

   assign cmd = pbf_cmd_type'(req_ch.command);
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign accept = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign emit_fire = (state_ff == ST_EMIT) && out_free;
   assign pop_rd = emit_fire && (sp_ff != '0);
   assign flat = lhs_ff < 102'(rhs_ff);
   assign at_limit = (level_ff >= SW'(MAX_DEPTH));
   assign rd_addr = AW'(sp_ff - SW'(1));

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_x = rsp_x_ff;
   assign rsp_ch.out_y = rsp_y_ff;
   assign rsp_ch.starts_contour = rsp_starts_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (cmd)
                  CMD_MOVE: state_in = ST_EMIT;
                  CMD_LINE, CMD_CLOSE: state_in = has_ff ? ST_EMIT : ST_IDLE;
                  CMD_QUAD: state_in = has_ff ? ST_QUAD : ST_IDLE;
                  CMD_CUBIC: state_in = has_ff ? ST_DECIDE : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_QUAD: if (step_ff == QUAD_LAST) state_in = ST_DECIDE;
         ST_DECIDE: state_in = at_limit ? ST_EMIT : ST_TEST;
         ST_TEST: if (step_ff == TEST_LAST) state_in = flat ? ST_EMIT : ST_SPLIT;
         ST_SPLIT: state_in = ST_DECIDE;
         ST_EMIT: if (out_free) state_in = (sp_ff == '0) ? ST_IDLE : ST_POP;
         ST_POP: state_in = ST_DECIDE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dx = 25'(px_ff[3]) - 25'(px_ff[0]);
      dy = 25'(py_ff[3]) - 25'(py_ff[0]);
      e1x = 25'(px_ff[1]) - 25'(px_ff[3]);
      e1y = 25'(py_ff[1]) - 25'(py_ff[3]);
      e2x = 25'(px_ff[2]) - 25'(px_ff[3]);
      e2y = 25'(py_ff[2]) - 25'(py_ff[3]);
      case (step_ff)
         4'd0: qd = 25'(px_ff[1]) - 25'(px_ff[0]);
         4'd1: qd = 25'(py_ff[1]) - 25'(py_ff[0]);
         4'd2: qd = e2x;
         default: qd = e2y;
      endcase
      case (step_ff)
         4'd1: qbase = px_ff[0];
         4'd2: qbase = py_ff[0];
         4'd3: qbase = px_ff[3];
         default: qbase = py_ff[3];
      endcase
      qt = {qd, 1'b0};
      qmag = qt[25] ? 26'(-qt) : 26'(qt);
      qu = qmag + 26'd1;
      qq = mul_ff[52:28];
      tt = qneg_ff ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
      qnew = COORD_W'(26'(qbase) + tt);
      prod = mul_ff[51:0];
      tdiff = t_ff - $signed(mul_ff[50:0]);
      tabs = tdiff[50] ? 50'(-tdiff) : 50'(tdiff);
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_QUAD) begin
         mul_a = $signed({2'b00, qu});
         mul_b = $signed(RECIP3);
      end else begin
         case (step_ff)
            4'd0: begin mul_a = 28'(e1x); mul_b = 28'(dy); end
            4'd1: begin mul_a = 28'(e1y); mul_b = 28'(dx); end
            4'd2: begin mul_a = 28'(e2x); mul_b = 28'(dy); end
            4'd3: begin mul_a = 28'(e2y); mul_b = 28'(dx); end
            4'd4: begin mul_a = 28'(dx); mul_b = 28'(dx); end
            4'd5: begin mul_a = 28'(dy); mul_b = 28'(dy); end
            4'd6: begin
               mul_a = $signed({2'b00, s_ff[25:0]});
               mul_b = $signed({2'b00, s_ff[25:0]});
            end
            4'd7: begin
               mul_a = $signed({3'b000, s_ff[50:26]});
               mul_b = $signed({2'b00, s_ff[25:0]});
            end
            4'd8: begin
               mul_a = $signed({3'b000, s_ff[50:26]});
               mul_b = $signed({3'b000, s_ff[50:26]});
            end
            4'd9: begin
               mul_a = $signed({4'b0000, tol_ff});
               mul_b = $signed({2'b00, dot_ff[25:0]});
            end
            4'd10: begin
               mul_a = $signed({4'b0000, tol_ff});
               mul_b = $signed({4'b0000, dot_ff[49:26]});
            end
            default: begin mul_a = '0; mul_b = '0; end
         endcase
      end
      ax = half_sum(px_ff[0], px_ff[1]);
      bx = half_sum(px_ff[1], px_ff[2]);
      cx = half_sum(px_ff[2], px_ff[3]);
      abx = half_sum(ax, bx);
      bcx = half_sum(bx, cx);
      mx = half_sum(abx, bcx);
      ay = half_sum(py_ff[0], py_ff[1]);
      by = half_sum(py_ff[1], py_ff[2]);
      cy = half_sum(py_ff[2], py_ff[3]);
      aby = half_sum(ay, by);
      bcy = half_sum(by, cy);
      my = half_sum(aby, bcy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= '0;
         sp_ff <= '0;
         level_ff <= '0;
         has_ff <= 1'b0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         cs_x_ff <= '0;
         cs_y_ff <= '0;
         tol_ff <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= (state_ff == ST_QUAD || state_ff == ST_TEST) && (state_in == state_ff)
                    ? step_ff + 4'd1 : 4'd0;
         if (csr_ch.valid) begin
            tol_ff <= csr_ch.flatness_tolerance;
         end
         if (accept) begin
            sp_ff <= '0;
            level_ff <= '0;
            case (cmd)
               CMD_MOVE: begin
                  has_ff <= 1'b1;
                  cur_x_ff <= req_ch.end_x;
                  cur_y_ff <= req_ch.end_y;
                  cs_x_ff <= req_ch.end_x;
                  cs_y_ff <= req_ch.end_y;
               end
               CMD_LINE, CMD_QUAD, CMD_CUBIC: begin
                  if (has_ff) begin
                     cur_x_ff <= req_ch.end_x;
                     cur_y_ff <= req_ch.end_y;
                  end
               end
               CMD_CLOSE: begin
                  if (has_ff) begin
                     cur_x_ff <= cs_x_ff;
                     cur_y_ff <= cs_y_ff;
                  end
               end
               default: begin
                  has_ff <= has_ff;
               end
            endcase
         end
         if (state_ff == ST_SPLIT) begin
            sp_ff <= sp_ff + SW'(1);
            level_ff <= level_ff + SW'(1);
         end
         if (pop_rd) begin
            sp_ff <= sp_ff - SW'(1);
         end
         if (state_ff == ST_POP) begin
            level_ff <= rd_lvl_ff;
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if (accept) begin
         px_ff[0] <= cur_x_ff;
         py_ff[0] <= cur_y_ff;
         px_ff[1] <= req_ch.ctrl1_x;
         py_ff[1] <= req_ch.ctrl1_y;
         px_ff[2] <= (cmd == CMD_QUAD) ? req_ch.ctrl1_x : req_ch.ctrl2_x;
         py_ff[2] <= (cmd == CMD_QUAD) ? req_ch.ctrl1_y : req_ch.ctrl2_y;
         px_ff[3] <= (cmd == CMD_CLOSE) ? cs_x_ff : req_ch.end_x;
         py_ff[3] <= (cmd == CMD_CLOSE) ? cs_y_ff : req_ch.end_y;
         starts_ff <= (cmd == CMD_MOVE) || (cmd == CMD_CLOSE);
      end
      if (state_ff == ST_QUAD) begin
         qneg_ff <= qd[24];
         case (step_ff)
            4'd1: px_ff[1] <= qnew;
            4'd2: py_ff[1] <= qnew;
            4'd3: px_ff[2] <= qnew;
            4'd4: py_ff[2] <= qnew;
            default: begin
            end
         endcase
      end
      if (state_ff == ST_TEST) begin
         case (step_ff)
            4'd1: t_ff <= mul_ff[50:0];
            4'd2: d_ff <= tabs;
            4'd3: t_ff <= mul_ff[50:0];
            4'd4: s_ff <= 51'(d_ff) + 51'(tabs);
            4'd5: dot_ff <= prod[49:0];
            4'd6: dot_ff <= dot_ff + prod[49:0];
            4'd7: lhs_ff <= 102'(prod);
            4'd8: lhs_ff <= lhs_ff + (102'(prod) << 27);
            4'd9: lhs_ff <= lhs_ff + (102'(prod) << 52);
            4'd10: rhs_ff <= 76'(prod);
            4'd11: rhs_ff <= rhs_ff + (76'(prod) << 26);
            default: rhs_ff <= rhs_ff;
         endcase
      end
      if (state_ff == ST_SPLIT) begin
         seg_mem[sp_ff[AW-1:0]] <= {py_ff[3], px_ff[3], cy, cx, bcy, bcx, my, mx};
         lvl_mem[sp_ff[AW-1:0]] <= level_ff + SW'(1);
         px_ff[1] <= ax;
         py_ff[1] <= ay;
         px_ff[2] <= abx;
         py_ff[2] <= aby;
         px_ff[3] <= mx;
         py_ff[3] <= my;
         starts_ff <= 1'b0;
      end
      if (pop_rd) begin
         rd_seg_ff <= seg_mem[rd_addr];
         rd_lvl_ff <= lvl_mem[rd_addr];
      end
      if (state_ff == ST_POP) begin
         for (int i = 0; i < 4; i++) begin
            px_ff[i] <= rd_seg_ff[2*i*COORD_W +: COORD_W];
            py_ff[i] <= rd_seg_ff[(2*i+1)*COORD_W +: COORD_W];
         end
      end
      if (emit_fire) begin
         rsp_x_ff <= px_ff[3];
         rsp_y_ff <= py_ff[3];
         rsp_starts_ff <= starts_ff;
         rsp_last_ff <= (sp_ff == '0);
      end
   end

   `PBF_ASSERT_IMP(a_idle_stack_empty, state_ff == ST_IDLE, sp_ff == '0)
   `PBF_ASSERT_IMP(a_stack_bound, 1'b1, sp_ff <= SW'(MAX_DEPTH) && sp_ff <= level_ff)
   `PBF_ASSERT_IMP(a_split_below_limit, state_ff == ST_SPLIT, level_ff < SW'(MAX_DEPTH))
   `PBF_ASSERT_NEXT(a_last_ends_run, emit_fire && sp_ff == '0, rsp_valid_ff && rsp_last_ff)
   `PBF_ASSERT_NEXT(a_last_to_idle, emit_fire && sp_ff == '0, state_ff == ST_IDLE)

endmodule

// ===== dv/tb_path_bezier_flattener.sv =====
`timescale 1ns / 1ps
module tb_path_bezier_flattener;
   import pbf_pkg::*;

   typedef struct {
      logic [CMD_W-1:0]          command;
      logic signed [COORD_W-1:0] end_x;
      logic signed [COORD_W-1:0] end_y;
      logic signed [COORD_W-1:0] ctrl1_x;
      logic signed [COORD_W-1:0] ctrl1_y;
      logic signed [COORD_W-1:0] ctrl2_x;
      logic signed [COORD_W-1:0] ctrl2_y;
   } path_request_type;

   typedef struct {
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               starts_contour;
      logic               last_of_run;
   } poly_point_type;

   typedef longint bezier_seg_type [8];

   localparam int DEPTH_LIMIT = 6;
   localparam int STACK_DEPTH = 7;
   localparam int POINT_LIMIT = 64;

   logic clock;
   logic reset;

   pbf_req_if req_ch ();
   pbf_rsp_if rsp_ch ();
   pbf_csr_if csr_ch ();

   path_bezier_flattener dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   path_request_type pending_requests[$];
   poly_point_type   expected_points[$];

   // Predictor state.
   logic [TOL_W-1:0] model_tolerance;
   longint           model_cur_x, model_cur_y, model_start_x, model_start_y;
   bit               model_has_contour;

   // Stimulus-side view of the path, used only to shape requests.
   longint gen_x, gen_y;
   bit     gen_has_contour;

   int  send_idle_pct;
   int  recv_stall_pct;
   int  hold_off_cycles;
   bit  request_taken;
   int  mismatch_count;
   int  requests_accepted;
   int  curves_accepted;
   int  points_checked;
   int  real_requests;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic longint two_thirds_of(longint d);
      longint t;
      t = 2 * d;
      return (t >= 0) ? (t + 1) / 3 : -((-t + 1) / 3);
   endfunction

   function automatic longint abs_of(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit piece_is_flat(bezier_seg_type p);
      longint      dx, dy, d2, d3;
      logic [127:0] spread, allowed, chord;
      dx = p[6] - p[0];
      dy = p[7] - p[1];
      d2 = abs_of((p[2] - p[6]) * dy - (p[3] - p[7]) * dx);
      d3 = abs_of((p[4] - p[6]) * dy - (p[5] - p[7]) * dx);
      spread = 128'(d2 + d3);
      chord = 128'(dx * dx) + 128'(dy * dy);
      allowed = 128'(model_tolerance) * chord;
      return (spread * spread) < allowed;
   endfunction

   function automatic void push_point(ref poly_point_type run[$], input longint x,
                                      input longint y, input bit starts);
      poly_point_type pt;
      pt.out_x = x[COORD_W-1:0];
      pt.out_y = y[COORD_W-1:0];
      pt.starts_contour = starts;
      pt.last_of_run = 1'b0;
      run.insert(run.size(), pt);
   endfunction

   function automatic void subdivide_curve(ref poly_point_type run[$],
                                           input bezier_seg_type init);
      bezier_seg_type p;
      bezier_seg_type stack_seg [STACK_DEPTH];
      int          stack_level [STACK_DEPTH];
      longint      a[2], b[2], c[2], ab[2], bc[2], m[2];
      int          level, sp, count;
      p = init;
      level = 0;
      sp = 0;
      count = 0;
      while (1) begin
         if (level >= DEPTH_LIMIT || sp >= STACK_DEPTH || piece_is_flat(p)) begin
            push_point(run, p[6], p[7], 1'b0);
            count++;
            if (sp == 0 || count >= POINT_LIMIT) break;
            sp--;
            p = stack_seg[sp];
            level = stack_level[sp];
         end else begin
            for (int i = 0; i < 2; i++) begin
               a[i] = (p[i] + p[2+i]) >>> 1;
               b[i] = (p[2+i] + p[4+i]) >>> 1;
               c[i] = (p[4+i] + p[6+i]) >>> 1;
               ab[i] = (a[i] + b[i]) >>> 1;
               bc[i] = (b[i] + c[i]) >>> 1;
               m[i] = (ab[i] + bc[i]) >>> 1;
            end
            stack_seg[sp] = '{m[0], m[1], bc[0], bc[1], c[0], c[1], p[6], p[7]};
            stack_level[sp] = level + 1;
            sp++;
            level++;
            p[2] = a[0];
            p[3] = a[1];
            p[4] = ab[0];
            p[5] = ab[1];
            p[6] = m[0];
            p[7] = m[1];
         end
      end
   endfunction

   function automatic void predict_points(path_request_type rq);
      poly_point_type run[$];
      bezier_seg_type seg;
      longint      ex, ey, c1x, c1y;
      ex = rq.end_x;
      ey = rq.end_y;
      c1x = rq.ctrl1_x;
      c1y = rq.ctrl1_y;
      if (rq.command == CMD_MOVE) begin
         push_point(run, ex, ey, 1'b1);
         model_cur_x = ex;
         model_cur_y = ey;
         model_start_x = ex;
         model_start_y = ey;
         model_has_contour = 1'b1;
      end else if (rq.command > CMD_CLOSE || !model_has_contour) begin
         return;
      end else if (rq.command == CMD_LINE) begin
         push_point(run, ex, ey, 1'b0);
         model_cur_x = ex;
         model_cur_y = ey;
      end else if (rq.command == CMD_CLOSE) begin
         push_point(run, model_start_x, model_start_y, 1'b1);
         model_cur_x = model_start_x;
         model_cur_y = model_start_y;
      end else begin
         seg[0] = model_cur_x;
         seg[1] = model_cur_y;
         seg[6] = ex;
         seg[7] = ey;
         if (rq.command == CMD_QUAD) begin
            seg[2] = model_cur_x + two_thirds_of(c1x - model_cur_x);
            seg[3] = model_cur_y + two_thirds_of(c1y - model_cur_y);
            seg[4] = ex + two_thirds_of(c1x - ex);
            seg[5] = ey + two_thirds_of(c1y - ey);
         end else begin
            seg[2] = c1x;
            seg[3] = c1y;
            seg[4] = longint'(rq.ctrl2_x);
            seg[5] = longint'(rq.ctrl2_y);
         end
         subdivide_curve(run, seg);
         model_cur_x = ex;
         model_cur_y = ey;
         curves_accepted++;
      end
      run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) expected_points.insert(expected_points.size(), run[i]);
   endfunction

   // Sender: the request at the head of the queue is consumed on acceptance.
   always @(posedge clock) begin
      request_taken = 1'b0;
      if (!reset && req_ch.valid && req_ch.ready) begin
         predict_points(pending_requests.pop_front());
         requests_accepted++;
         request_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || request_taken) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.command <= pending_requests[0].command;
            req_ch.end_x <= pending_requests[0].end_x;
            req_ch.end_y <= pending_requests[0].end_y;
            req_ch.ctrl1_x <= pending_requests[0].ctrl1_x;
            req_ch.ctrl1_y <= pending_requests[0].ctrl1_y;
            req_ch.ctrl2_x <= pending_requests[0].ctrl2_x;
            req_ch.ctrl2_y <= pending_requests[0].ctrl2_y;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off in the first random phase.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      poly_point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         points_checked++;
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected point x=%0d y=%0d", rsp_ch.out_x, rsp_ch.out_y);
         end else begin
            want = expected_points.pop_front();
            if (rsp_ch.out_x !== want.out_x || rsp_ch.out_y !== want.out_y ||
                  rsp_ch.starts_contour !== want.starts_contour ||
                  rsp_ch.last_of_run !== want.last_of_run) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Point mismatch: expected x=%h y=%h s=%b l=%b, got x=%h y=%h s=%b l=%b",
                     want.out_x, want.out_y, want.starts_contour, want.last_of_run,
                     rsp_ch.out_x, rsp_ch.out_y, rsp_ch.starts_contour, rsp_ch.last_of_run);
            end
         end
      end
   end

   function automatic path_request_type make_request(logic [CMD_W-1:0] cmd, longint ex,
         longint ey, longint c1x, longint c1y, longint c2x, longint c2y);
      path_request_type rq;
      rq.command = cmd;
      rq.end_x = ex[COORD_W-1:0];
      rq.end_y = ey[COORD_W-1:0];
      rq.ctrl1_x = c1x[COORD_W-1:0];
      rq.ctrl1_y = c1y[COORD_W-1:0];
      rq.ctrl2_x = c2x[COORD_W-1:0];
      rq.ctrl2_y = c2y[COORD_W-1:0];
      return rq;
   endfunction

   function automatic longint pick_coord(longint near);
      longint v;
      if ($urandom_range(3) == 0) begin
         v = $signed($urandom_range(24'hFFFFFF, 0) - 32'sd8388608);
      end else begin
         v = near + $signed($urandom_range(8192, 0)) - 4096;
         if (v > 8388607) v = 8388607;
         if (v < -8388608) v = -8388608;
      end
      return v;
   endfunction

   function automatic void queue_request(path_request_type rq);
      pending_requests.insert(pending_requests.size(), rq);
      if (rq.command == CMD_MOVE) begin
         gen_has_contour = 1'b1;
         gen_x = rq.end_x;
         gen_y = rq.end_y;
         real_requests++;
      end else if (rq.command <= CMD_CLOSE && gen_has_contour) begin
         real_requests++;
         if (rq.command == CMD_CLOSE) begin
            gen_x = gen_x;
         end else begin
            gen_x = rq.end_x;
            gen_y = rq.end_y;
         end
      end
   endfunction

   function automatic void queue_random(int count);
      path_request_type rq;
      int            roll, target;
      logic [CMD_W-1:0] cmd;
      target = real_requests + count;
      while (real_requests < target) begin
         roll = $urandom_range(99);
         if (!gen_has_contour || roll < 10) cmd = CMD_MOVE;
         else if (roll < 28) cmd = CMD_LINE;
         else if (roll < 53) cmd = CMD_QUAD;
         else if (roll < 80) cmd = CMD_CUBIC;
         else if (roll < 93) cmd = CMD_CLOSE;
         else cmd = CMD_W'($urandom_range(7, 5));
         rq = make_request(cmd, pick_coord(gen_x), pick_coord(gen_y), pick_coord(gen_x),
            pick_coord(gen_y), pick_coord(gen_x), pick_coord(gen_y));
         queue_request(rq);
      end
   endfunction

   task automatic wait_idle();
      while (pending_requests.size() > 0 || expected_points.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_W-1:0] value);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.flatness_tolerance = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      model_tolerance = value;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   initial begin
      longint maxc, minc;
      logic [TOL_W-1:0] tol_plan [4];
      maxc = 8388607;
      minc = -8388608;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.command = '0;
      req_ch.end_x = '0;
      req_ch.end_y = '0;
      req_ch.ctrl1_x = '0;
      req_ch.ctrl1_y = '0;
      req_ch.ctrl2_x = '0;
      req_ch.ctrl2_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.flatness_tolerance = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_off_cycles = 0;
      mismatch_count = 0;
      requests_accepted = 0;
      curves_accepted = 0;
      points_checked = 0;
      real_requests = 0;
      model_tolerance = TOL_RESET;
      model_cur_x = 0;
      model_cur_y = 0;
      model_start_x = 0;
      model_start_y = 0;
      model_has_contour = 1'b0;
      gen_x = 0;
      gen_y = 0;
      gen_has_contour = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset tolerance.
      queue_request(make_request(CMD_LINE, 100, 200, 0, 0, 0, 0));
      queue_request(make_request(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
      queue_request(make_request(CMD_CUBIC, 500, 500, 100, 0, 0, 100));
      queue_request(make_request(CMD_QUAD, 50, 60, 70, 80, 0, 0));
      queue_request(make_request(3'd5, 1, 2, 3, 4, 5, 6));
      queue_request(make_request(CMD_MOVE, maxc, maxc, 0, 0, 0, 0));
      queue_request(make_request(3'd6, -1, -1, -1, -1, -1, -1));
      queue_request(make_request(3'd7, 0, 0, 0, 0, 0, 0));
      queue_request(make_request(CMD_LINE, minc, minc, maxc, maxc, maxc, maxc));
      queue_request(make_request(CMD_QUAD, maxc, maxc, minc, maxc, 0, 0));
      queue_request(make_request(CMD_CUBIC, minc, minc, maxc, minc, minc, maxc));
      queue_request(make_request(CMD_CUBIC, minc, minc, 4000, -3000, -5000, 6000));
      queue_request(make_request(CMD_CUBIC, minc, minc, minc, minc, minc, minc));
      queue_request(make_request(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
      queue_request(make_request(CMD_MOVE, 256, -256, 0, 0, 0, 0));
      queue_request(make_request(CMD_LINE, 1280, 640, 0, 0, 0, 0));
      queue_request(make_request(CMD_QUAD, 2560, 0, 1920, 1920, 0, 0));
      queue_request(make_request(CMD_CUBIC, 0, 0, 3000, -2000, -1000, 2500));
      queue_request(make_request(CMD_QUAD, 0, 0, 0, 0, 0, 0));
      queue_request(make_request(CMD_CLOSE, -1, -1, -1, -1, -1, -1));
      queue_request(make_request(CMD_MOVE, minc, maxc, maxc, minc, maxc, minc));
      queue_request(make_request(CMD_CLOSE, 0, 0, 0, 0, 0, 0));
      wait_idle();

      tol_plan = '{24'd0, 24'hFFFFFF, TOL_W'($urandom_range(24'hFFFFFF, 0)), 24'd300};
      for (int ph = 0; ph < 4; ph++) begin
         write_tolerance(tol_plan[ph]);
         case (ph)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
               hold_off_cycles = 400;
            end
            1: begin
               send_idle_pct = 57;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 57;
            end
            default: begin
               send_idle_pct = 23;
               recv_stall_pct = 23;
            end
         endcase
         queue_random(20);
         wait_idle();
      end
      write_tolerance(TOL_RESET);
      queue_random(4);
      wait_idle();

      $display("Accepted %0d path requests (%0d curves), checked %0d polyline points.",
         requests_accepted, curves_accepted, points_checked);
      $display("Tolerance settings covered zero, maximum, reset and random values.");
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("Mismatches: %0d, points still expected: %0d", mismatch_count,
            expected_points.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Timeout with %0d requests pending and %0d points expected",
         pending_requests.size(), expected_points.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== path_bezier_flattener.f =====
+incdir+design
design/pbf_pkg.sv
design/pbf_if.sv
design/path_bezier_flattener.sv
dv/tb_path_bezier_flattener.sv
